### rtl/core/kmp_substring_matcher_core_defines.svh
// ----------------------------------------------------------------------------
// kmp_substring_matcher_core_defines
// Assertion macros shared by the matcher RTL.
// ----------------------------------------------------------------------------
`ifndef KMP_SUBSTRING_MATCHER_CORE_DEFINES_SVH
`define KMP_SUBSTRING_MATCHER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define KMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define KMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Request and status codes and the control bundle for the matcher cell chain.
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int SYM_BITS     = 8;
    localparam int POS_OUT_BITS = 32;
    localparam int HIT_GROUP    = 16;   // cells per first-level hit OR

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_TEXT   = 2'd2,
        REQ_END    = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_SEARCHING = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOMATCH   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef struct packed {
        logic                clear;    // drop pattern and match state
        logic                append;   // load symbol into the cell after the tail
        logic                step;     // advance match state by one text symbol
        logic                tail0;    // pattern empty: virtual cell 0 is the tail
        logic [SYM_BITS-1:0] symbol;
    } t_chain_ctrl;

endpackage

### rtl/core/kmp_cell.sv
// ----------------------------------------------------------------------------
// kmp_cell
// One pattern position: stored byte, prefix-matched bit and tail token.
// ----------------------------------------------------------------------------
module kmp_cell
    import kmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chain_ctrl i_ctrl,
    input  logic        i_act_prev,   // prefix one shorter matched so far
    input  logic        i_tail_prev,  // previous cell holds the last pattern byte
    output logic        o_act,
    output logic        o_tail,
    output logic        o_hit         // full pattern matched on this step
);

    logic [SYM_BITS-1:0] r_sym;
    logic                r_act;
    logic                r_tail;
    logic                w_ext;

    // prefix extends by this cell's byte
    assign w_ext  = i_act_prev && (r_sym == i_ctrl.symbol);
    assign o_hit  = w_ext && r_tail;
    assign o_act  = r_act;
    assign o_tail = r_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_tail <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_act  <= 1'b0;
            r_tail <= 1'b0;
        end else if (i_ctrl.append) begin
            r_tail <= i_tail_prev;
        end else if (i_ctrl.step) begin
            r_act  <= w_ext;
        end
    end

    // pattern byte: no reset, only read once written
    always_ff @(posedge i_clk) begin
        if (i_ctrl.append && i_tail_prev) begin
            r_sym <= i_ctrl.symbol;
        end
    end

endmodule

### rtl/core/kmp_chain.sv
// ----------------------------------------------------------------------------
// kmp_chain
// Row of pattern cells plus a registered first level of the hit OR tree.
// ----------------------------------------------------------------------------
module kmp_chain
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX = 255
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_chain_ctrl           i_ctrl,
    // per-group hit, registered; one bit per HIT_GROUP cells
    output logic [(PATTERN_MAX + HIT_GROUP - 1) / HIT_GROUP - 1:0] o_grp
);

    localparam int GROUPS = (PATTERN_MAX + HIT_GROUP - 1) / HIT_GROUP;
    localparam int PAD    = GROUPS * HIT_GROUP;

    logic [PATTERN_MAX:0]   w_act;   // index 0 is the empty prefix
    logic [PATTERN_MAX:0]   w_tail;
    logic [PAD-1:0]         w_hit;
    logic [GROUPS-1:0]      r_grp;

    assign w_act[0]  = 1'b1;
    assign w_tail[0] = i_ctrl.tail0;

    generate
        for (genvar k = 1; k <= PATTERN_MAX; k++) begin : g_cell
            kmp_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (i_ctrl),
                .i_act_prev  (w_act[k-1]),
                .i_tail_prev (w_tail[k-1]),
                .o_act       (w_act[k]),
                .o_tail      (w_tail[k]),
                .o_hit       (w_hit[k-1])
            );
        end
        if (PAD > PATTERN_MAX) begin : g_pad
            assign w_hit[PAD-1:PATTERN_MAX] = '0;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            for (int g = 0; g < GROUPS; g++) begin
                r_grp[g] <= |w_hit[g*HIT_GROUP +: HIT_GROUP];
            end
        end
    end

    assign o_grp = r_grp;

endmodule

### rtl/core/kmp_substring_matcher_core.sv
// ----------------------------------------------------------------------------
// kmp_substring_matcher_core
// Flow: the accept cycle updates the cell row; in S_FIN the registered hit
//   groups are ORed and the result is formed, waiting while m_axis stalls.
//   No new input beat is taken until that result enters the output register.
// Reset: synchronous, active low; empty pattern, search state cleared.
// ----------------------------------------------------------------------------
//
// Search runs as a shift-and row of PATTERN_MAX cells. Cell k holds pattern
// byte k and a bit saying that pattern bytes 1..k match the latest text
// bytes. A one-hot tail token marks the last pattern byte; a text step whose
// prefix reaches the tail cell is a complete match. This tracks the same set
// of matched prefixes as a failure-link walk, so the first match position is
// identical, including appends that extend a running search.
//
// Cells past the tail can only pick up a matched bit after the tail cell
// matched, which closes the search, so their unwritten bytes never matter.
module kmp_substring_matcher_core
    import kmp_pkg::*;
#(
    parameter int PATTERN_MAX   = 255,
    parameter int POSITION_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic [7:0]  s_axis_tuser,   // [1:0] req_type, [7:2] unused
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] match_position
    output logic [7:0]  m_axis_tuser    // [2:0] status, [7:3] zero
);

    `include "kmp_substring_matcher_core_defines.svh"

    localparam int LW     = $clog2(PATTERN_MAX + 1);
    localparam int GROUPS = (PATTERN_MAX + HIT_GROUP - 1) / HIT_GROUP;
    localparam int PW     = (POSITION_BITS > POS_OUT_BITS) ? POSITION_BITS : POS_OUT_BITS;

    typedef enum logic {
        S_IDLE,
        S_FIN
    } t_state;

    t_state                   r_state, n_state;
    logic [LW-1:0]            r_len, n_len;
    logic [POSITION_BITS-1:0] r_tpos, n_tpos;
    logic                     r_found, n_found;
    logic [POS_OUT_BITS-1:0]  r_fpos, n_fpos;
    logic                     r_ended, n_ended;
    t_req                     r_req, n_req;      // request held for the result cycle
    logic                     r_full, n_full;    // append refused
    logic                     r_step, n_step;    // text byte went through the cells
    logic                     r_out_valid, n_out_valid;
    t_status                  r_out_status, n_out_status;
    logic [POS_OUT_BITS-1:0]  r_out_pos, n_out_pos;

    logic                     w_accept;
    t_req                     w_req;
    logic                     w_len_full;
    logic                     w_hit;
    logic [GROUPS-1:0]        w_grp;
    logic [PW-1:0]            w_diff;
    t_chain_ctrl              w_ctrl;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_req         = t_req'(s_axis_tuser[1:0]);
    assign w_len_full    = (r_len >= LW'(PATTERN_MAX));

    // chain control comes straight from the accepted beat
    always_comb begin
        w_ctrl        = '0;
        w_ctrl.symbol = s_axis_tdata;
        w_ctrl.tail0  = (r_len == '0);
        w_ctrl.clear  = w_accept && (w_req == REQ_CLEAR);
        w_ctrl.append = w_accept && (w_req == REQ_APPEND) && !w_len_full;
        w_ctrl.step   = w_accept && (w_req == REQ_TEXT) && !r_found && !r_ended
                        && (r_len != '0);
    end

    kmp_chain #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_grp   (w_grp)
    );

    // start of the match; the low 32 bits are right even if this wraps
    assign w_diff = PW'(r_tpos) - PW'(r_len) + PW'(1);
    assign w_hit  = r_step && (|w_grp);

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_tpos       = r_tpos;
        n_found      = r_found;
        n_fpos       = r_fpos;
        n_ended      = r_ended;
        n_req        = r_req;
        n_full       = r_full;
        n_step       = r_step;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_FIN;
                    n_req   = w_req;
                    n_full  = 1'b0;
                    n_step  = 1'b0;
                    unique case (w_req)
                        REQ_CLEAR: begin
                            n_len   = '0;
                            n_tpos  = '0;
                            n_found = 1'b0;
                            n_fpos  = '0;
                            n_ended = 1'b0;
                        end
                        REQ_APPEND: begin
                            if (w_len_full) begin
                                n_full = 1'b1;
                            end else begin
                                n_len = r_len + LW'(1);
                            end
                        end
                        REQ_TEXT: begin
                            if (!r_found && !r_ended) begin
                                if (r_len == '0) begin
                                    // empty pattern matches at once
                                    n_found = 1'b1;
                                    n_fpos  = POS_OUT_BITS'(1);
                                end else begin
                                    n_step = 1'b1;
                                    if (r_tpos != '1) begin
                                        n_tpos = r_tpos + POSITION_BITS'(1);
                                    end
                                end
                            end
                        end
                        REQ_END: begin
                            if (!r_found) begin
                                if (r_len == '0) begin
                                    n_found = 1'b1;
                                    n_fpos  = POS_OUT_BITS'(1);
                                end else begin
                                    n_ended = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FIN: begin
                // wait here until the output register has room
                if (!r_out_valid || m_axis_tready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (w_hit) begin
                        n_found = 1'b1;
                        n_fpos  = w_diff[POS_OUT_BITS-1:0];
                    end
                    // position register stays zero until a match
                    n_out_pos = w_hit ? w_diff[POS_OUT_BITS-1:0] : r_fpos;
                    unique case (r_req)
                        REQ_CLEAR:  n_out_status = ST_ACCEPTED;
                        REQ_APPEND: n_out_status = r_full ? ST_FULL : ST_ACCEPTED;
                        REQ_TEXT: begin
                            if (r_step) begin
                                n_out_status = w_hit ? ST_FOUND : ST_SEARCHING;
                            end else begin
                                n_out_status = r_found ? ST_FOUND : ST_NOMATCH;
                            end
                        end
                        REQ_END:    n_out_status = r_found ? ST_FOUND : ST_NOMATCH;
                        default:    n_out_status = ST_ACCEPTED;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_tpos      <= '0;
            r_found     <= 1'b0;
            r_fpos      <= '0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_tpos      <= n_tpos;
            r_found     <= n_found;
            r_fpos      <= n_fpos;
            r_ended     <= n_ended;
            r_out_valid <= n_out_valid;
        end
        r_req        <= n_req;
        r_full       <= n_full;
        r_step       <= n_step;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pos;
    assign m_axis_tuser  = {5'b0, r_out_status};

    // a search-in-progress reply never carries a position
    `KMP_ASSERT_NOW(a_searching_no_pos, m_axis_tvalid && (m_axis_tuser[2:0] == ST_SEARCHING), m_axis_tdata == '0, "searching result with nonzero position")
    // one beat in flight: no accept in the cycle after an accept
    `KMP_ASSERT_NEXT(a_one_in_flight, w_accept, !s_axis_tready, "input accepted while busy")
    // a found match sticks until a clear
    `KMP_ASSERT_NEXT(a_found_sticky, r_found && !w_ctrl.clear, r_found, "found flag dropped without clear")
    // pattern length never runs past the cell row
    `KMP_ASSERT_NOW(a_len_bound, w_ctrl.append, r_len < LW'(PATTERN_MAX), "append beyond pattern limit")

endmodule

### tb/sv/tb_kmp_substring_matcher_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kmp_substring_matcher_core
// Self-checking bench for the streaming substring matcher. A shadow KMP
// search predicts status and first-match position for every request beat.
// Stimulus is a short directed opener, then mostly well-formed search
// sessions (clear, pattern, text, end of text) with random content, some
// noise beats, and a single full-length pattern run. Both stream sides idle
// at random, and one long output stall backs the block up.
// ----------------------------------------------------------------------------
module tb_kmp_substring_matcher_core;
    import kmp_pkg::*;

    localparam int PATTERN_MAX   = 255;
    localparam int POSITION_BITS = 32;
    localparam int ITEM_TARGET   = 1450;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 300;   // long output stall
    localparam int HOLD_AFTER    = 300;   // results seen before that stall
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        t_req       req;
        logic [7:0] sym;
    } t_kmp_request;

    typedef struct {
        t_status     status;
        logic [31:0] pos;
    } t_kmp_result;

    // output-side ready schedules
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_PATTERN,
        RDY_EVERY3,
        RDY_SPARSE
    } t_rdy_mode;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    // DUT ports
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_tdata = 8'd0;   // [7:0] symbol
    logic [7:0]  s_tuser = 8'd0;   // [1:0] req_type, [7:2] zero
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_tdata;          // [31:0] match_position
    logic [7:0]  m_tuser;          // [2:0] status, [7:3] zero

    kmp_substring_matcher_core #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Shadow search state (1-based pattern, failure links as in classic KMP)
    // ------------------------------------------------------------------------
    logic [7:0]  shadow_pat  [0:PATTERN_MAX] = '{default: 8'd0};
    int          shadow_link [0:PATTERN_MAX] = '{default: 0};
    int          shadow_len    = 0;
    int          shadow_build  = 0;
    int          shadow_scan   = 1;
    logic [31:0] shadow_tpos   = 32'd0;
    bit          shadow_hit    = 1'b0;
    logic [31:0] shadow_hitpos = 32'd0;
    bit          shadow_closed = 1'b0;

    t_kmp_request request_q[$];
    t_kmp_result  pending_results[$];

    int n_queued    = 0;
    int n_directed  = 0;
    int n_accepted  = 0;
    int n_results   = 0;
    int n_found     = 0;
    int n_nomatch   = 0;
    int n_refused   = 0;
    int n_errors    = 0;

    // Advance the shadow search by one request and return the reply.
    function automatic t_kmp_result next_match_result(t_kmp_request rq);
        t_kmp_result r;
        int          k;
        int          nl;
        r.status = ST_ACCEPTED;
        case (rq.req)
            REQ_CLEAR: begin
                shadow_len    = 0;
                shadow_build  = 0;
                shadow_scan   = 1;
                shadow_tpos   = 32'd0;
                shadow_hit    = 1'b0;
                shadow_hitpos = 32'd0;
                shadow_closed = 1'b0;
            end
            REQ_APPEND: begin
                if (shadow_len >= PATTERN_MAX) begin
                    r.status = ST_FULL;
                end else begin
                    nl = shadow_len + 1;
                    shadow_pat[nl] = rq.sym;
                    if (nl == 1) begin
                        shadow_link[1] = 0;
                        shadow_build   = 0;
                    end else begin
                        // link of the new tail comes from the previous byte
                        k = shadow_build;
                        while (k != 0 && shadow_pat[nl-1] != shadow_pat[k])
                            k = shadow_link[k];
                        k++;
                        shadow_link[nl] = k;
                        shadow_build    = k;
                    end
                    shadow_len = nl;
                end
            end
            REQ_TEXT: begin
                if (shadow_hit) begin
                    r.status = ST_FOUND;
                end else if (shadow_closed) begin
                    r.status = ST_NOMATCH;
                end else if (shadow_len == 0) begin
                    // empty pattern matches right away
                    shadow_hit    = 1'b1;
                    shadow_hitpos = 32'd1;
                    r.status      = ST_FOUND;
                end else begin
                    if (shadow_tpos != 32'hFFFF_FFFF)
                        shadow_tpos++;
                    k = shadow_scan;
                    while (k != 0 && rq.sym != shadow_pat[k])
                        k = shadow_link[k];
                    k++;
                    shadow_scan = k;
                    if (k > shadow_len) begin
                        shadow_hit    = 1'b1;
                        shadow_hitpos = shadow_tpos - 32'(shadow_len) + 32'd1;
                        r.status      = ST_FOUND;
                    end else begin
                        r.status = ST_SEARCHING;
                    end
                end
            end
            default: begin
                if (!shadow_hit && shadow_len == 0) begin
                    shadow_hit    = 1'b1;
                    shadow_hitpos = 32'd1;
                end
                if (shadow_hit) begin
                    r.status = ST_FOUND;
                end else begin
                    shadow_closed = 1'b1;
                    r.status      = ST_NOMATCH;
                end
            end
        endcase
        r.pos = shadow_hit ? shadow_hitpos : 32'd0;
        return r;
    endfunction

    task automatic queue_beat(t_req req, logic [7:0] sym);
        t_kmp_request rq;
        rq.req = req;
        rq.sym = sym;
        request_q.push_back(rq);
        n_queued++;
    endtask

    task automatic note_error(string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: bursts of beats separated by random gaps
    // ------------------------------------------------------------------------
    int           burst_left = 1;
    int           gap_left   = 0;
    bit           drv_busy;
    t_kmp_request drv_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid    <= 1'b0;
            s_tdata    <= 8'd0;
            s_tuser    <= 8'd0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            drv_busy = s_valid;
            if (s_valid && s_ready) begin
                drv_beat = request_q.pop_front();
                pending_results.push_back(next_match_result(drv_beat));
                n_accepted++;
                drv_busy = 1'b0;
            end
            // a beat on offer stays put until taken
            if (!drv_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    s_valid <= 1'b1;
                    s_tdata <= request_q[0].sym;
                    s_tuser <= {6'd0, request_q[0].req};
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output ready: a schedule that changes whenever rdy_phase wraps, plus one
    // long stall that fills the block while the driver keeps offering beats
    // ------------------------------------------------------------------------
    t_rdy_mode   rdy_mode  = RDY_ALWAYS;
    logic [31:0] rdy_pat   = 32'd0;
    int          rdy_phase = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && n_results >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            rdy_phase = (rdy_phase + 1) % 32;
            if (rdy_phase == 0) begin
                rdy_mode = t_rdy_mode'($urandom_range(0, 3));
                rdy_pat  = $urandom;
            end
            case (rdy_mode)
                RDY_ALWAYS:  m_ready <= 1'b1;
                RDY_PATTERN: m_ready <= rdy_pat[rdy_phase];
                RDY_EVERY3:  m_ready <= (rdy_phase % 3 == 0);
                default:     m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: each taken beat against the oldest prediction
    // ------------------------------------------------------------------------
    t_kmp_result mon_exp;

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                note_error($sformatf("result beat with nothing pending: status %0d pos %0d",
                                     m_tuser[2:0], m_tdata));
            end else begin
                mon_exp = pending_results.pop_front();
                if (m_tuser[2:0] !== mon_exp.status)
                    note_error($sformatf("result %0d status: expected %0d, got %0d",
                                         n_results, mon_exp.status, m_tuser[2:0]));
                if (m_tdata !== mon_exp.pos)
                    note_error($sformatf("result %0d position: expected %0d, got %0d",
                                         n_results, mon_exp.pos, m_tdata));
                case (mon_exp.status)
                    ST_FOUND:   n_found++;
                    ST_NOMATCH: n_nomatch++;
                    ST_FULL:    n_refused++;
                    default:    ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int         plen;
        int         tlen;
        int         off;
        int         nalph;
        int         nnoise;
        int         i;
        bit         embed;
        bit         big_done;
        logic [7:0] alph [3];
        logic [7:0] spat [16];
        logic [7:0] big_pat [1:PATTERN_MAX];
        logic [7:0] a_sym;
        logic [7:0] b_sym;

        big_done = 1'b0;

        // empty pattern: text and end of text both hit at 1
        queue_beat(REQ_TEXT,   8'h00);
        queue_beat(REQ_TEXT,   8'hFF);   // after a match: ignored
        queue_beat(REQ_CLEAR,  8'hFF);
        queue_beat(REQ_END,    8'h00);
        // pattern 00 FF 00 against 00 00 FF 00: mismatch walk, hit at 2
        queue_beat(REQ_CLEAR,  8'h00);
        queue_beat(REQ_APPEND, 8'h00);
        queue_beat(REQ_APPEND, 8'hFF);
        queue_beat(REQ_APPEND, 8'h00);
        queue_beat(REQ_TEXT,   8'h00);
        queue_beat(REQ_TEXT,   8'h00);
        queue_beat(REQ_TEXT,   8'hFF);
        queue_beat(REQ_TEXT,   8'h00);
        queue_beat(REQ_APPEND, 8'hFF);   // append after a match
        queue_beat(REQ_END,    8'hFF);
        // no match at end, then the search stays closed
        queue_beat(REQ_CLEAR,  8'h00);
        queue_beat(REQ_APPEND, 8'h7E);
        queue_beat(REQ_TEXT,   8'h81);
        queue_beat(REQ_END,    8'h00);
        queue_beat(REQ_TEXT,   8'h7E);
        queue_beat(REQ_END,    8'h7E);
        // append in the middle of a running search: AB, text CA, +C, text BC
        queue_beat(REQ_CLEAR,  8'h00);
        queue_beat(REQ_APPEND, 8'h41);
        queue_beat(REQ_APPEND, 8'h42);
        queue_beat(REQ_TEXT,   8'h43);
        queue_beat(REQ_TEXT,   8'h41);
        queue_beat(REQ_APPEND, 8'h43);
        queue_beat(REQ_TEXT,   8'h42);
        queue_beat(REQ_TEXT,   8'h43);
        n_directed = n_queued;

        while (n_queued < ITEM_TARGET) begin
            if (!big_done && n_queued > 400) begin
                // full-length pattern, refused appends, then text that holds it
                big_done = 1'b1;
                a_sym = 8'($urandom_range(0, 255));
                b_sym = ~a_sym;
                queue_beat(REQ_CLEAR, 8'($urandom_range(0, 255)));
                for (i = 1; i <= PATTERN_MAX; i++) begin
                    big_pat[i] = ($urandom_range(0, 7) == 0) ? b_sym : a_sym;
                    queue_beat(REQ_APPEND, big_pat[i]);
                end
                for (i = 0; i < 3; i++)
                    queue_beat(REQ_APPEND, 8'($urandom_range(0, 255)));
                for (i = 0; i < 6; i++)
                    queue_beat(REQ_TEXT, a_sym);
                for (i = 1; i <= PATTERN_MAX; i++)
                    queue_beat(REQ_TEXT, big_pat[i]);
                queue_beat(REQ_END, 8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 99) < 8) begin
                // noise: any request, any byte
                nnoise = $urandom_range(1, 6);
                for (i = 0; i < nnoise; i++)
                    queue_beat(t_req'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
                // well-formed session over a small random alphabet
                nalph = $urandom_range(1, 3);
                for (i = 0; i < 3; i++)
                    alph[i] = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 19))
                    0:         plen = 0;
                    1, 2, 3,
                    4, 5:      plen = $urandom_range(5, 12);
                    default:   plen = $urandom_range(1, 4);
                endcase
                if ($urandom_range(0, 9) != 0)
                    queue_beat(REQ_CLEAR, 8'($urandom_range(0, 255)));
                for (i = 0; i < plen; i++) begin
                    spat[i] = alph[$urandom_range(0, nalph - 1)];
                    queue_beat(REQ_APPEND, spat[i]);
                end
                tlen  = $urandom_range(0, 24);
                embed = (tlen >= plen) && ($urandom_range(0, 1) == 1);
                off   = embed ? $urandom_range(0, tlen - plen) : 0;
                for (i = 0; i < tlen; i++) begin
                    if ($urandom_range(0, 24) == 0)
                        queue_beat(REQ_APPEND, alph[$urandom_range(0, nalph - 1)]);
                    if (embed && i >= off && i < off + plen)
                        queue_beat(REQ_TEXT, spat[i - off]);
                    else if ($urandom_range(0, 19) == 0)
                        queue_beat(REQ_TEXT, 8'($urandom_range(0, 255)));
                    else
                        queue_beat(REQ_TEXT, alph[$urandom_range(0, nalph - 1)]);
                end
                if ($urandom_range(0, 19) < 17) begin
                    queue_beat(REQ_END, 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 4) == 0) begin
                        nnoise = $urandom_range(1, 3);
                        for (i = 0; i < nnoise; i++)
                            queue_beat(REQ_TEXT, alph[$urandom_range(0, nalph - 1)]);
                    end
                end
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every beat taken, every prediction checked, then a short drain
        while (n_accepted < n_queued)
            @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d request beats (%0d directed) and %0d result beats.",
                 n_accepted, n_directed, n_results);
        $display("Seen: %0d found, %0d no match at end, %0d refused appends; %0d errors.",
                 n_found, n_nomatch, n_refused, n_errors);
        if (n_errors == 0)
            $display("** kmp_substring_matcher_core: PASSED **");
        else
            $display("** kmp_substring_matcher_core: FAILED **");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("Timeout: %0d of %0d beats taken, %0d results pending.",
                 n_accepted, n_queued, pending_results.size());
        $display("** kmp_substring_matcher_core: FAILED **");
        $finish;
    end

endmodule
